### rtl/cbd_pkg.sv
// cbd_pkg: types, codes and bus decode helpers for the cpu bus decoder
// with sprite dma; no dependencies
package cbd_pkg;

   typedef enum logic [2:0] {
      KIND_WRITE  = 3'd0,
      KIND_READ   = 3'd1,
      KIND_SAMPLE = 3'd2,
      KIND_DMA    = 3'd3,
      KIND_STALL  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      TGT_NONE   = 3'd0,
      TGT_RAM    = 3'd1,
      TGT_PPU    = 3'd2,
      TGT_APU    = 3'd3,
      TGT_PAD1   = 3'd4,
      TGT_PAD2   = 3'd5,
      TGT_STROBE = 3'd6,
      TGT_CART   = 3'd7
   } target_type;

   // one routed word travelling down the pipeline
   typedef struct packed {
      target_type  tgt;
      logic [15:0] dev;
      logic        wr;
      logic [7:0]  data;
      logic        ram_wr;
      logic        use_ram;
      logic        use_latch;
      logic        dma_busy;
      logic        stall_busy;
   } item_type;

   localparam int          RAM_WINDOW    = 8192;
   localparam int          RECIP_SHIFT   = 26;
   localparam logic [15:0] RAM_TOP       = 16'h1FFF;
   localparam logic [15:0] PPU_TOP       = 16'h3FFF;
   localparam logic [15:0] APU_FIRST     = 16'h4000;
   localparam logic [15:0] APU_LAST      = 16'h4013;
   localparam logic [15:0] OAM_DMA_PORT  = 16'h4014;
   localparam logic [15:0] APU_STATUS    = 16'h4015;
   localparam logic [15:0] PAD_ONE_PORT  = 16'h4016;
   localparam logic [15:0] PAD_TWO_PORT  = 16'h4017;
   localparam logic [15:0] PPU_REG_MASK  = 16'h0007;
   localparam logic [15:0] OAM_DATA_REG  = 16'h0004;
   localparam logic [2:0]  STALL_LOAD    = 3'd4;

   function automatic target_type read_target(input logic [15:0] addr);
      target_type t;
      if (addr <= RAM_TOP) begin
         t = TGT_RAM;
      end else if (addr <= PPU_TOP) begin
         t = TGT_PPU;
      end else if (addr == PAD_ONE_PORT) begin
         t = TGT_PAD1;
      end else if (addr == PAD_TWO_PORT) begin
         t = TGT_PAD2;
      end else begin
         t = TGT_CART;
      end
      return t;
   endfunction

   function automatic target_type write_target(input logic [15:0] addr);
      target_type t;
      if (addr <= RAM_TOP) begin
         t = TGT_RAM;
      end else if (addr <= PPU_TOP) begin
         t = TGT_PPU;
      end else if ((addr >= APU_FIRST && addr <= APU_LAST) ||
                   addr == APU_STATUS || addr == PAD_TWO_PORT) begin
         t = TGT_APU;
      end else if (addr == OAM_DMA_PORT) begin
         t = TGT_NONE;
      end else if (addr == PAD_ONE_PORT) begin
         t = TGT_STROBE;
      end else begin
         t = TGT_CART;
      end
      return t;
   endfunction

endpackage

### rtl/cbd_ram.sv
// cbd_ram: generic single-clock ram, one write and one registered read port
// no dependencies
module cbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cpu_bus_decoder_with_sprite_dma.sv
// cpu_bus_decoder_with_sprite_dma: bus decode, work ram, sprite dma sequencer
// and sample stall counter; uses cbd_pkg and cbd_ram
//
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  kind address write_data odd_cycle
//                                      ext_data ext_valid
// rsp      out  rsp_valid / rsp_stall  target device_address is_write data
//                                      dma_busy stall_busy
//
// one word accepted per cycle while req_stall is low; the result is registered at each stage below
// stages: decode and quotient, ram index and ram access, result register
// after reset every byte of the work ram is cleared to zero with req_stall high
// rsp_stall freezes the whole pipeline while a result is valid, and req_stall follows it
module cpu_bus_decoder_with_sprite_dma #(
   parameter int RAM_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic        req_odd_cycle,
   input  logic [7:0]  req_ext_data,
   input  logic        req_ext_valid,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_target,
   output logic [15:0] rsp_device_address,
   output logic        rsp_is_write,
   output logic [7:0]  rsp_data,
   output logic        rsp_dma_busy,
   output logic        rsp_stall_busy
);
   import cbd_pkg::*;

   localparam int AW  = $clog2(RAM_BYTES);
   localparam int Q_W = $clog2(RAM_WINDOW / RAM_BYTES + 1);
   localparam logic [18:0] RECIP =
      19'(((2 ** RECIP_SHIFT) + RAM_BYTES - 1) / RAM_BYTES);
   localparam logic [AW-1:0] CLR_LAST = AW'(RAM_BYTES - 1);

   // control state
   logic [7:0] page_ff, page_in;
   logic [7:0] offset_ff, offset_in;
   logic       running_ff, running_in;
   logic       align_ff, align_in;
   logic [7:0] latched_ff, latched_in;
   logic [2:0] stall_cnt_ff, stall_cnt_in;
   logic       clr_busy_ff;
   logic [AW-1:0] clr_idx_ff;

   // pipeline
   logic          s1_valid_ff, s2_valid_ff, out_valid_ff;
   item_type      s1_item_ff, s2_item_ff;
   item_type      s1_fwd;
   logic [12:0]   s1_addr_ff;
   logic [Q_W-1:0] s1_q_ff;
   logic          s1_dma_read_ff, s2_dma_read_ff, dec_dma_read;
   logic          s2_latches;
   item_type      dec_item;
   logic [15:0]   eff_addr;
   logic [7:0]    ext_byte;
   logic [31:0]   recip_prod;
   logic [13:0]   q_times_n;
   logic [13:0]   idx_full;
   logic [AW-1:0] ram_idx;
   logic [7:0]    ram_rdata;
   logic          advance;
   logic          accept;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;

   logic [2:0]  out_target_ff;
   logic [15:0] out_dev_ff;
   logic        out_wr_ff;
   logic [7:0]  out_data_ff;
   logic        out_dma_busy_ff;
   logic        out_stall_busy_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance || clr_busy_ff;
   assign accept    = req_valid && !req_stall;

   assign eff_addr = (kind_type'(req_kind) == KIND_DMA) ? {page_ff, offset_ff} : req_address;
   assign ext_byte = req_ext_valid ? req_ext_data : 8'd0;

   // decode and next control state
   always_comb begin
      dec_item     = '0;
      dec_item.tgt = TGT_NONE;
      page_in      = page_ff;
      offset_in    = offset_ff;
      running_in   = running_ff;
      align_in     = align_ff;
      stall_cnt_in = stall_cnt_ff;
      case (kind_type'(req_kind))
         KIND_WRITE: begin
            dec_item.wr   = 1'b1;
            dec_item.data = req_write_data;
            dec_item.dev  = req_address;
            dec_item.tgt  = write_target(req_address);
            if (req_address <= RAM_TOP) begin
               dec_item.ram_wr = 1'b1;
            end else if (req_address <= PPU_TOP) begin
               dec_item.dev = req_address & PPU_REG_MASK;
            end else if (req_address == OAM_DMA_PORT) begin
               page_in    = req_write_data;
               offset_in  = 8'd0;
               running_in = 1'b1;
               align_in   = 1'b1;
            end
         end
         KIND_READ, KIND_SAMPLE: begin
            if (kind_type'(req_kind) == KIND_SAMPLE) begin
               stall_cnt_in = STALL_LOAD;
            end
            dec_item.tgt  = read_target(req_address);
            dec_item.data = ext_byte;
            dec_item.dev  = req_address;
            if (req_address <= RAM_TOP) begin
               dec_item.use_ram = 1'b1;
            end else if (req_address <= PPU_TOP) begin
               dec_item.dev = req_address & PPU_REG_MASK;
            end
         end
         KIND_DMA: begin
            if (running_ff) begin
               if (align_ff) begin
                  if (req_odd_cycle) begin
                     align_in = 1'b0;
                  end
               end else if (!req_odd_cycle) begin
                  dec_item.tgt       = read_target(eff_addr);
                  dec_item.data      = ext_byte;
                  dec_item.dev       = eff_addr;
                  dec_item.use_latch = 1'b0;
                  if (eff_addr <= RAM_TOP) begin
                     dec_item.use_ram = 1'b1;
                  end else if (eff_addr <= PPU_TOP) begin
                     dec_item.dev = eff_addr & PPU_REG_MASK;
                  end
               end else begin
                  dec_item.tgt       = TGT_PPU;
                  dec_item.dev       = OAM_DATA_REG;
                  dec_item.wr        = 1'b1;
                  dec_item.use_latch = 1'b1;
                  offset_in          = offset_ff + 8'd1;
                  if (offset_ff == 8'hFF) begin
                     running_in = 1'b0;
                     align_in   = 1'b1;
                  end
               end
            end
         end
         KIND_STALL: begin
            if (stall_cnt_ff != 3'd0) begin
               stall_cnt_in = stall_cnt_ff - 3'd1;
            end
         end
         default: begin
         end
      endcase
      dec_item.dma_busy   = running_in;
      dec_item.stall_busy = (stall_cnt_in != 3'd0);
   end

   // dma read ticks latch the byte they return
   assign s2_latches = s2_valid_ff && advance &&
                       !s2_item_ff.use_latch && !s2_item_ff.wr &&
                       s2_item_ff.tgt != TGT_NONE && s2_dma_read_ff;

   assign dec_dma_read = (kind_type'(req_kind) == KIND_DMA) && running_ff && !align_ff &&
                         !req_odd_cycle;

   always_comb begin
      latched_in = latched_ff;
      if (s2_latches) begin
         latched_in = s2_item_ff.use_ram ? ram_rdata : s2_item_ff.data;
      end
   end

   // quotient of the ram window address by the ram size
   assign recip_prod = {19'd0, eff_addr[12:0]} * {13'd0, RECIP};

   // remainder gives the mirrored ram index
   assign q_times_n = 14'(32'(s1_q_ff) * RAM_BYTES);
   assign idx_full  = {1'b0, s1_addr_ff} - q_times_n;
   assign ram_idx   = idx_full[AW-1:0];

   always_comb begin
      s1_fwd = s1_item_ff;
      if (s1_item_ff.tgt == TGT_RAM) begin
         s1_fwd.dev = 16'(ram_idx);
      end
   end

   assign ram_wr_en   = clr_busy_ff || (s1_valid_ff && advance && s1_item_ff.ram_wr);
   assign ram_wr_addr = clr_busy_ff ? clr_idx_ff : ram_idx;
   assign ram_wr_data = clr_busy_ff ? 8'd0 : s1_item_ff.data;
   assign ram_rd_en   = s1_valid_ff && advance && s1_item_ff.use_ram;

   cbd_ram #(
      .WIDTH (8),
      .DEPTH (RAM_BYTES)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_idx),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff      <= 8'd0;
         offset_ff    <= 8'd0;
         running_ff   <= 1'b0;
         align_ff     <= 1'b0;
         latched_ff   <= 8'd0;
         stall_cnt_ff <= 3'd0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            page_ff      <= page_in;
            offset_ff    <= offset_in;
            running_ff   <= running_in;
            align_ff     <= align_in;
            stall_cnt_ff <= stall_cnt_in;
         end
         latched_ff <= latched_in;
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == CLR_LAST) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (advance) begin
            s1_valid_ff  <= accept;
            s2_valid_ff  <= s1_valid_ff;
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff     <= dec_item;
         s1_addr_ff     <= eff_addr[12:0];
         s1_q_ff        <= recip_prod[RECIP_SHIFT +: Q_W];
         s1_dma_read_ff <= dec_dma_read;
         s2_item_ff     <= s1_fwd;
         s2_dma_read_ff <= s1_dma_read_ff;
         out_target_ff     <= s2_item_ff.tgt;
         out_dev_ff        <= s2_item_ff.dev;
         out_wr_ff         <= s2_item_ff.wr;
         out_dma_busy_ff   <= s2_item_ff.dma_busy;
         out_stall_busy_ff <= s2_item_ff.stall_busy;
         if (s2_item_ff.use_latch) begin
            out_data_ff <= latched_ff;
         end else if (s2_item_ff.use_ram) begin
            out_data_ff <= ram_rdata;
         end else begin
            out_data_ff <= s2_item_ff.data;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_target         = out_target_ff;
   assign rsp_device_address = out_dev_ff;
   assign rsp_is_write       = out_wr_ff;
   assign rsp_data           = out_data_ff;
   assign rsp_dma_busy       = out_dma_busy_ff;
   assign rsp_stall_busy     = out_stall_busy_ff;

endmodule

### tb/tb_cpu_bus_decoder_with_sprite_dma.sv
// tb_cpu_bus_decoder_with_sprite_dma: self-checking bench for the cpu bus decoder
// with sprite dma, a clocked driver and monitor around a bus predictor with its own ram
// and dma state; depends on cbd_pkg and the rtl top level cpu_bus_decoder_with_sprite_dma
`timescale 1ns / 100ps

module tb_cpu_bus_decoder_with_sprite_dma;
   import cbd_pkg::*;

   localparam int RAM_BYTES = 2048;

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic        odd;
      logic [7:0]  ext_data;
      logic        ext_valid;
   } bus_word_type;

   typedef struct {
      target_type  tgt;
      logic [15:0] dev;
      logic        wr;
      logic [7:0]  data;
      logic        dma_busy;
      logic        stall_busy;
   } bus_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        req_odd_cycle = 1'b0;
   logic [7:0]  req_ext_data = '0;
   logic        req_ext_valid = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_target;
   logic [15:0] rsp_device_address;
   logic        rsp_is_write;
   logic [7:0]  rsp_data;
   logic        rsp_dma_busy;
   logic        rsp_stall_busy;

   cpu_bus_decoder_with_sprite_dma #(.RAM_BYTES(RAM_BYTES)) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_address        (req_address),
      .req_write_data     (req_write_data),
      .req_odd_cycle      (req_odd_cycle),
      .req_ext_data       (req_ext_data),
      .req_ext_valid      (req_ext_valid),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_target         (rsp_target),
      .rsp_device_address (rsp_device_address),
      .rsp_is_write       (rsp_is_write),
      .rsp_data           (rsp_data),
      .rsp_dma_busy       (rsp_dma_busy),
      .rsp_stall_busy     (rsp_stall_busy)
   );

   // predictor state
   logic [7:0] sim_ram [RAM_BYTES];
   logic [7:0] oam_page;
   logic [7:0] oam_offset;
   logic       oam_active;
   logic       oam_align;
   logic [7:0] oam_latch;
   logic [2:0] stall_left;

   bus_word_type   pending_words [$];
   bus_result_type routed_results [$];
   bus_word_type   cur_word;

   int words_total;
   int words_done;
   int results_seen;
   int errors;
   int cycle_count;
   int n_oam_bytes;
   int n_stall_loads;

   wire calm = (cycle_count >= 2400) && (cycle_count < 2900);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bus_result_type route_read_word(input logic [15:0] addr,
                                                      input logic [7:0] ext_data,
                                                      input logic ext_valid);
      bus_result_type r;
      int idx;
      r.wr = 1'b0;
      r.data = ext_valid ? ext_data : 8'h00;
      r.dev = addr;
      if (addr <= RAM_TOP) begin
         idx = addr % RAM_BYTES;
         r.tgt = TGT_RAM;
         r.dev = 16'(idx);
         r.data = sim_ram[idx];
      end else if (addr <= PPU_TOP) begin
         r.tgt = TGT_PPU;
         r.dev = addr & PPU_REG_MASK;
      end else if (addr == PAD_ONE_PORT) begin
         r.tgt = TGT_PAD1;
      end else if (addr == PAD_TWO_PORT) begin
         r.tgt = TGT_PAD2;
      end else begin
         r.tgt = TGT_CART;
      end
      return r;
   endfunction

   function automatic bus_result_type predict_word(input bus_word_type w);
      bus_result_type r;
      int idx;
      r.tgt = TGT_NONE;
      r.dev = '0;
      r.wr = 1'b0;
      r.data = '0;
      if (w.kind == KIND_WRITE) begin
         r.wr = 1'b1;
         r.data = w.wdata;
         r.dev = w.addr;
         if (w.addr <= RAM_TOP) begin
            idx = w.addr % RAM_BYTES;
            sim_ram[idx] = w.wdata;
            r.tgt = TGT_RAM;
            r.dev = 16'(idx);
         end else if (w.addr <= PPU_TOP) begin
            r.tgt = TGT_PPU;
            r.dev = w.addr & PPU_REG_MASK;
         end else if ((w.addr >= APU_FIRST && w.addr <= APU_LAST) ||
                      w.addr == APU_STATUS || w.addr == PAD_TWO_PORT) begin
            r.tgt = TGT_APU;
         end else if (w.addr == OAM_DMA_PORT) begin
            oam_page = w.wdata;
            oam_offset = '0;
            oam_active = 1'b1;
            oam_align = 1'b1;
         end else if (w.addr == PAD_ONE_PORT) begin
            r.tgt = TGT_STROBE;
         end else begin
            r.tgt = TGT_CART;
         end
      end else if (w.kind == KIND_READ || w.kind == KIND_SAMPLE) begin
         if (w.kind == KIND_SAMPLE) begin
            stall_left = STALL_LOAD;
            n_stall_loads++;
         end
         r = route_read_word(w.addr, w.ext_data, w.ext_valid);
      end else if (w.kind == KIND_DMA) begin
         if (oam_active) begin
            if (oam_align) begin
               if (w.odd) oam_align = 1'b0;
            end else if (!w.odd) begin
               r = route_read_word({oam_page, oam_offset}, w.ext_data, w.ext_valid);
               oam_latch = r.data;
            end else begin
               r.tgt = TGT_PPU;
               r.dev = OAM_DATA_REG;
               r.wr = 1'b1;
               r.data = oam_latch;
               oam_offset = oam_offset + 8'd1;
               n_oam_bytes++;
               if (oam_offset == 8'd0) begin
                  oam_active = 1'b0;
                  oam_align = 1'b1;
               end
            end
         end
      end else if (w.kind == KIND_STALL) begin
         if (stall_left != 3'd0) stall_left = stall_left - 3'd1;
      end
      r.dma_busy = oam_active;
      r.stall_busy = (stall_left != 3'd0);
      return r;
   endfunction

   function automatic void add_word(input logic [2:0] kind, input logic [15:0] addr,
                                    input logic [7:0] wdata, input logic odd,
                                    input logic [7:0] ext_data, input logic ext_valid);
      bus_word_type w;
      w.kind = kind;
      w.addr = addr;
      w.wdata = wdata;
      w.odd = odd;
      w.ext_data = ext_data;
      w.ext_valid = ext_valid;
      pending_words.push_back(w);
   endfunction

   function automatic void add_filler();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         add_word(KIND_WRITE, 16'($urandom_range(0, RAM_TOP)), 8'($urandom), 1'($urandom),
                  8'($urandom), 1'($urandom));
      end else if (pick < 70) begin
         add_word(KIND_READ, (pick < 50) ? 16'($urandom_range(0, RAM_TOP)) : 16'($urandom),
                  8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 80) begin
         add_word(KIND_SAMPLE, 16'($urandom), 8'($urandom), 1'($urandom),
                  8'($urandom), 1'($urandom));
      end else begin
         add_word(KIND_STALL, 16'($urandom), 8'($urandom), 1'($urandom),
                  8'($urandom), 1'($urandom));
      end
   endfunction

   function automatic void note_failure(input string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            routed_results.push_back(predict_word(cur_word));
            words_done++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
               cur_word = pending_words.pop_front();
               req_kind <= cur_word.kind;
               req_address <= cur_word.addr;
               req_write_data <= cur_word.wdata;
               req_odd_cycle <= cur_word.odd;
               req_ext_data <= cur_word.ext_data;
               req_ext_valid <= cur_word.ext_valid;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall and result check
   always @(posedge clock) begin
      bus_result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 27);
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (routed_results.size() == 0) begin
               note_failure($sformatf("unexpected word target=%0d dev=%h",
                                      rsp_target, rsp_device_address));
            end else begin
               e = routed_results.pop_front();
               if (rsp_target !== e.tgt || rsp_device_address !== e.dev ||
                   rsp_is_write !== e.wr || rsp_data !== e.data ||
                   rsp_dma_busy !== e.dma_busy || rsp_stall_busy !== e.stall_busy) begin
                  // fields: target/device/write/data/dma busy/stall busy
                  note_failure($sformatf(
                     "word %0d exp %0d/%h/%b/%h/%b/%b got %0d/%h/%b/%h/%b/%b",
                     results_seen, e.tgt, e.dev, e.wr, e.data, e.dma_busy, e.stall_busy,
                     rsp_target, rsp_device_address, rsp_is_write, rsp_data,
                     rsp_dma_busy, rsp_stall_busy));
               end
            end
         end
      end
   end

   initial begin
      #4000000;
      $display("tb_cpu_bus_decoder_with_sprite_dma: errors");
      $finish;
   end

   initial begin
      int pick;
      int n;
      logic parity;
      for (int i = 0; i < RAM_BYTES; i++) sim_ram[i] = 8'h00;
      oam_page = '0;
      oam_offset = '0;
      oam_active = 1'b0;
      oam_align = 1'b0;
      oam_latch = '0;
      stall_left = '0;
      words_done = 0;
      results_seen = 0;
      errors = 0;
      cycle_count = 0;
      n_oam_bytes = 0;
      n_stall_loads = 0;

      // directed: decode edges, mirrors, absent devices, stall counter, idle kinds
      add_word(KIND_WRITE, 16'h0000, 8'hFF, 1'b0, 8'h00, 1'b0);
      add_word(KIND_WRITE, 16'h07FF, 8'hA5, 1'b1, 8'hFF, 1'b1);
      add_word(KIND_WRITE, 16'h0800, 8'h5A, 1'b0, 8'h00, 1'b0);
      add_word(KIND_READ,  16'h1FFF, 8'h00, 1'b0, 8'h33, 1'b1);
      add_word(KIND_READ,  16'h0000, 8'h00, 1'b0, 8'h00, 1'b0);
      add_word(KIND_WRITE, 16'h2000, 8'h11, 1'b0, 8'h00, 1'b0);
      add_word(KIND_READ,  16'h3FFF, 8'h00, 1'b0, 8'hFF, 1'b1);
      add_word(KIND_READ,  16'h2004, 8'h00, 1'b0, 8'hCC, 1'b0);
      add_word(KIND_WRITE, APU_FIRST, 8'h01, 1'b0, 8'h00, 1'b0);
      add_word(KIND_WRITE, APU_LAST, 8'h02, 1'b0, 8'h00, 1'b0);
      add_word(KIND_WRITE, APU_STATUS, 8'h03, 1'b0, 8'h00, 1'b0);
      add_word(KIND_WRITE, PAD_TWO_PORT, 8'h04, 1'b0, 8'h00, 1'b0);
      add_word(KIND_WRITE, PAD_ONE_PORT, 8'h01, 1'b0, 8'h00, 1'b0);
      add_word(KIND_READ,  PAD_ONE_PORT, 8'h00, 1'b0, 8'h41, 1'b1);
      add_word(KIND_READ,  PAD_TWO_PORT, 8'h00, 1'b0, 8'h40, 1'b1);
      add_word(KIND_READ,  OAM_DMA_PORT, 8'h00, 1'b0, 8'h77, 1'b1);
      add_word(KIND_READ,  APU_FIRST, 8'h00, 1'b0, 8'h88, 1'b0);
      add_word(KIND_WRITE, 16'hFFFF, 8'h99, 1'b1, 8'h00, 1'b0);
      add_word(KIND_WRITE, 16'h4018, 8'h98, 1'b0, 8'h00, 1'b0);
      add_word(KIND_SAMPLE, 16'h8000, 8'h00, 1'b0, 8'hEE, 1'b1);
      repeat (5) add_word(KIND_STALL, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b0);
      add_word(KIND_DMA, 16'h0000, 8'h00, 1'b1, 8'h00, 1'b0);
      add_word(3'd5, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 1'b1);
      add_word(3'd7, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b0);

      // random mix with short sprite transfers that get restarted
      repeat (8) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            add_filler();
         end else if (pick < 75) begin
            add_word(KIND_WRITE, OAM_DMA_PORT,
                     ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 31)) : 8'($urandom),
                     1'($urandom), 8'($urandom), 1'($urandom));
            parity = 1'($urandom);
            n = $urandom_range(2, 20);
            repeat (n) begin
               add_word(KIND_DMA, 16'($urandom), 8'($urandom), parity,
                        8'($urandom), 1'($urandom));
               parity = ~parity;
            end
         end else begin
            add_word(3'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                     8'($urandom), 1'($urandom));
         end
      end

      // one full 256 byte transfer from a ram page with cpu traffic interleaved
      add_word(KIND_WRITE, OAM_DMA_PORT, 8'($urandom_range(0, 31)), 1'b0, 8'($urandom), 1'b0);
      parity = 1'b0;
      repeat (516) begin
         if ($urandom_range(0, 99) < 2) add_filler();
         add_word(KIND_DMA, 16'($urandom), 8'($urandom), parity, 8'($urandom), 1'($urandom));
         parity = ~parity;
      end
      repeat (4) add_word(3'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
                          8'($urandom), 1'($urandom));
      words_total = pending_words.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (words_done == words_total);
      wait (results_seen >= words_total);
      repeat (8) @(posedge clock);
      $display("ran %0d bus words: %0d sprite dma bytes moved, %0d sample stalls loaded",
               words_total, n_oam_bytes, n_stall_loads);
      if (errors == 0) begin
         $display("tb_cpu_bus_decoder_with_sprite_dma: clean");
      end else begin
         $display("%0d mismatches in total", errors);
         $display("tb_cpu_bus_decoder_with_sprite_dma: errors");
      end
      $finish;
   end

endmodule
